[rtl/core/bfsp_pkg.sv]
// ----------------------------------------------------------------------------
// Shortest-path engine package
// Widths, codes and the command and status groups that pass between the
// controller and the datapath.
// ----------------------------------------------------------------------------
package bfsp_pkg;

    localparam int MAX_NODES = 1024;
    localparam int MAX_EDGES = 4096;
    localparam int NODE_W    = $clog2(MAX_NODES);
    localparam int CNT_W     = $clog2(MAX_NODES + 1);
    localparam int EDGE_AW   = $clog2(MAX_EDGES);
    localparam int ECNT_W    = $clog2(MAX_EDGES + 1);
    localparam int WEIGHT_W  = 32;
    localparam int DIST_W    = 48;
    localparam int EDGE_W    = 2 * NODE_W + WEIGHT_W;
    localparam int NREC_W    = DIST_W + 1;

    typedef enum logic [1:0] {
        KIND_ADD   = 2'd0,
        KIND_CLR   = 2'd1,
        KIND_RUN   = 2'd2,
        KIND_QUERY = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_UNREACH  = 2'd1,
        ST_NEGCYC   = 2'd2,
        ST_REJECTED = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        OUT_ADD,
        OUT_RUN_BAD,
        OUT_RUN_DONE,
        OUT_QUERY
    } t_out_sel;

    typedef struct packed {
        logic                accept;
        logic                sweep_wr;
        logic                seed_wr;
        logic                node_rd;
        logic                calc;
        logic                upd;
        logic                detect;
        logic [NODE_W-1:0]   sweep_addr;
        logic [EDGE_AW-1:0]  edge_addr;
        logic                out_load;
        t_out_sel            out_sel;
    } t_cmd;

    typedef struct packed {
        logic [ECNT_W-1:0] edge_count;
        logic [CNT_W-1:0]  n_act;
        logic              src_bad;
        logic              out_free;
    } t_stat;

endpackage

[rtl/core/bfsp_if.sv]
// ----------------------------------------------------------------------------
// Shortest-path engine channels
// Valid/ready channels for input words and result words.
// ----------------------------------------------------------------------------
interface bfsp_in_if import bfsp_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic [1:0]                 kind;
    logic [NODE_W-1:0]          edge_from;
    logic [NODE_W-1:0]          edge_to;
    logic signed [WEIGHT_W-1:0] edge_weight;
    logic [NODE_W-1:0]          node;

    modport source (output valid, kind, edge_from, edge_to, edge_weight, node,
                    input ready);
    modport sink   (input valid, kind, edge_from, edge_to, edge_weight, node,
                    output ready);
endinterface

interface bfsp_out_if import bfsp_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [1:0]               status;
    logic signed [DIST_W-1:0] distance;

    modport source (output valid, status, distance, input ready);
    modport sink   (input valid, status, distance, output ready);
endinterface

[rtl/core/bfsp_ctrl.sv]
// ----------------------------------------------------------------------------
// Shortest-path engine controller
// Sequences edge loads, queries, and the clear sweep and relaxation passes
// of a run.
// ----------------------------------------------------------------------------
module bfsp_ctrl import bfsp_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [1:0] i_kind,
    input  t_stat      i_stat,
    output logic       o_ready,
    output t_cmd       o_cmd
);

    typedef enum logic [8:0] {
        S_IDLE   = 9'b000000001,
        S_SWEEP  = 9'b000000010,
        S_SEED   = 9'b000000100,
        S_PSTART = 9'b000001000,
        S_EFETCH = 9'b000010000,
        S_NREAD  = 9'b000100000,
        S_CALC   = 9'b001000000,
        S_UPD    = 9'b010000000,
        S_QRESP  = 9'b100000000
    } t_state;

    t_state             r_state, n_state;
    logic [NODE_W-1:0]  r_sweep, n_sweep;
    logic [EDGE_AW-1:0] r_eidx,  n_eidx;
    logic [CNT_W-1:0]   r_pass,  n_pass;
    logic               w_detect;
    logic               w_last_edge;
    logic               w_accept;

    assign o_ready     = (r_state == S_IDLE) && i_stat.out_free;
    assign w_accept    = o_ready && i_valid;
    assign w_detect    = (r_pass == i_stat.n_act);
    assign w_last_edge = ({1'b0, r_eidx} + ECNT_W'(1)) == i_stat.edge_count;

    always_comb begin
        n_state = r_state;
        n_sweep = r_sweep;
        n_eidx  = r_eidx;
        n_pass  = r_pass;
        o_cmd            = '0;
        o_cmd.out_sel    = OUT_ADD;
        o_cmd.accept     = w_accept;
        o_cmd.sweep_addr = r_sweep;
        o_cmd.edge_addr  = r_eidx;
        o_cmd.detect     = w_detect;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    unique case (t_kind'(i_kind))
                        KIND_ADD: begin
                            o_cmd.out_load = 1'b1;
                            o_cmd.out_sel  = OUT_ADD;
                        end
                        KIND_CLR: begin
                        end
                        KIND_RUN: begin
                            n_sweep = '0;
                            n_state = S_SWEEP;
                        end
                        KIND_QUERY: begin
                            n_state = S_QRESP;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_SWEEP: begin
                o_cmd.sweep_wr = 1'b1;
                n_sweep = r_sweep + NODE_W'(1);
                if (&r_sweep) begin
                    if (i_stat.src_bad) begin
                        o_cmd.out_load = 1'b1;
                        o_cmd.out_sel  = OUT_RUN_BAD;
                        n_state = S_IDLE;
                    end else begin
                        n_state = S_SEED;
                    end
                end
            end
            S_SEED: begin
                o_cmd.seed_wr = 1'b1;
                n_pass  = CNT_W'(1);
                n_state = S_PSTART;
            end
            S_PSTART: begin
                n_eidx = '0;
                if (i_stat.edge_count == '0) begin
                    if (w_detect) begin
                        o_cmd.out_load = 1'b1;
                        o_cmd.out_sel  = OUT_RUN_DONE;
                        n_state = S_IDLE;
                    end else begin
                        n_pass = r_pass + CNT_W'(1);
                    end
                end else begin
                    n_state = S_EFETCH;
                end
            end
            S_EFETCH: begin
                n_state = S_NREAD;
            end
            S_NREAD: begin
                o_cmd.node_rd = 1'b1;
                n_state = S_CALC;
            end
            S_CALC: begin
                o_cmd.calc = 1'b1;
                n_state = S_UPD;
            end
            S_UPD: begin
                o_cmd.upd = 1'b1;
                n_eidx = r_eidx + EDGE_AW'(1);
                if (w_last_edge) begin
                    if (w_detect) begin
                        o_cmd.out_load = 1'b1;
                        o_cmd.out_sel  = OUT_RUN_DONE;
                        n_state = S_IDLE;
                    end else begin
                        n_pass  = r_pass + CNT_W'(1);
                        n_state = S_PSTART;
                    end
                end else begin
                    n_state = S_EFETCH;
                end
            end
            S_QRESP: begin
                o_cmd.out_load = 1'b1;
                o_cmd.out_sel  = OUT_QUERY;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_sweep <= '0;
            r_eidx  <= '0;
            r_pass  <= '0;
        end else begin
            r_state <= n_state;
            r_sweep <= n_sweep;
            r_eidx  <= n_eidx;
            r_pass  <= n_pass;
        end
    end

endmodule

[rtl/core/bfsp_dpath.sv]
// ----------------------------------------------------------------------------
// Shortest-path engine datapath
// Edge memory, node memory, relaxation arithmetic, flags and result register.
// ----------------------------------------------------------------------------
module bfsp_dpath import bfsp_pkg::*; (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  t_cmd                       i_cmd,
    input  logic [1:0]                 i_kind,
    input  logic [NODE_W-1:0]          i_edge_from,
    input  logic [NODE_W-1:0]          i_edge_to,
    input  logic signed [WEIGHT_W-1:0] i_edge_weight,
    input  logic [NODE_W-1:0]          i_node,
    input  logic                       i_cfg_we,
    input  logic [CNT_W-1:0]           i_cfg_wdata,
    input  logic                       i_out_ready,
    output t_stat                      o_stat,
    output logic                       o_out_valid,
    output logic [1:0]                 o_out_status,
    output logic signed [DIST_W-1:0]   o_out_distance
);

    logic [EDGE_W-1:0] edge_mem [MAX_EDGES];
    logic [NREC_W-1:0] node_mem [MAX_NODES];

    logic [CNT_W-1:0]         r_num_nodes;
    logic [ECNT_W-1:0]        r_count;
    logic                     r_negcyc;
    logic                     r_ran;
    logic [NODE_W-1:0]        r_node;
    logic [EDGE_W-1:0]        r_edge;
    logic [NREC_W-1:0]        r_rd_a, r_rd_b;
    logic [DIST_W-1:0]        r_sum;
    logic                     r_lo;
    logic                     r_ok;
    logic                     r_rb;
    logic [DIST_W-1:0]        r_db;
    logic                     r_out_valid;
    t_status                  r_out_status;
    logic [DIST_W-1:0]        r_out_dist;

    logic [CNT_W-1:0]    w_n;
    logic [NODE_W-1:0]   w_esrc, w_edst;
    logic [WEIGHT_W-1:0] w_ew;
    logic                w_add_ok;
    logic                w_in_range;
    logic [DIST_W:0]     w_sum;
    logic                w_improved;
    logic                w_neg_hit;
    logic                w_nwe;
    logic [NODE_W-1:0]   w_waddr;
    logic [NREC_W-1:0]   w_wdata;
    logic [NODE_W-1:0]   w_raddr_a;
    logic                w_accept_kind_run;

    // Node count in use, clamped to one..MAX_NODES.
    always_comb begin
        if (r_num_nodes == '0) begin
            w_n = CNT_W'(1);
        end else if (r_num_nodes > CNT_W'(MAX_NODES)) begin
            w_n = CNT_W'(MAX_NODES);
        end else begin
            w_n = r_num_nodes;
        end
    end

    assign {w_esrc, w_edst, w_ew} = r_edge;
    assign w_add_ok = (r_count < ECNT_W'(MAX_EDGES))
                   && ({1'b0, i_edge_from} < w_n) && ({1'b0, i_edge_to} < w_n);
    assign w_in_range = ({1'b0, w_esrc} < w_n) && ({1'b0, w_edst} < w_n);
    assign w_sum = {r_rd_a[DIST_W-1], r_rd_a[DIST_W-1:0]}
                 + {{(DIST_W + 1 - WEIGHT_W){w_ew[WEIGHT_W-1]}}, w_ew};
    assign w_improved = r_ok && (!r_rb || ($signed(r_sum) < $signed(r_db)));
    assign w_accept_kind_run = i_cmd.accept && (t_kind'(i_kind) == KIND_RUN);
    // This edge either hit the lower limit or could still relax in the
    // detection pass.
    assign w_neg_hit = i_cmd.upd && ((r_ok && r_lo) || (i_cmd.detect && w_improved));

    assign w_nwe = i_cmd.sweep_wr || i_cmd.seed_wr
                || (i_cmd.upd && !i_cmd.detect && w_improved);
    always_comb begin
        if (i_cmd.sweep_wr) begin
            w_waddr = i_cmd.sweep_addr;
            w_wdata = '0;
        end else if (i_cmd.seed_wr) begin
            w_waddr = r_node;
            w_wdata = {1'b1, {DIST_W{1'b0}}};
        end else begin
            w_waddr = w_edst;
            w_wdata = {1'b1, r_sum};
        end
    end
    assign w_raddr_a = i_cmd.node_rd ? w_esrc : i_node;

    // Edge memory: one write and one registered read per cycle.
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && (t_kind'(i_kind) == KIND_ADD) && w_add_ok) begin
            edge_mem[r_count[EDGE_AW-1:0]] <= {i_edge_from, i_edge_to, i_edge_weight};
        end
        r_edge <= edge_mem[i_cmd.edge_addr];
    end

    // Node memory: reached bit over distance; one write, two registered reads.
    always_ff @(posedge i_clk) begin
        if (w_nwe) begin
            node_mem[w_waddr] <= w_wdata;
        end
        r_rd_a <= node_mem[w_raddr_a];
        r_rd_b <= node_mem[w_edst];
    end

    // Relaxation stage registers; saturation to the 48-bit range.
    always_ff @(posedge i_clk) begin
        if (i_cmd.calc) begin
            r_ok <= w_in_range && r_rd_a[DIST_W];
            r_rb <= r_rd_b[DIST_W];
            r_db <= r_rd_b[DIST_W-1:0];
            r_lo <= w_sum[DIST_W] && !w_sum[DIST_W-1];
            if (!w_sum[DIST_W] && w_sum[DIST_W-1]) begin
                r_sum <= {1'b0, {(DIST_W - 1){1'b1}}};
            end else if (w_sum[DIST_W] && !w_sum[DIST_W-1]) begin
                r_sum <= {1'b1, {(DIST_W - 1){1'b0}}};
            end else begin
                r_sum <= w_sum[DIST_W-1:0];
            end
        end
        if (i_cmd.accept) begin
            r_node <= i_node;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_nodes <= CNT_W'(MAX_NODES);
            r_count     <= '0;
            r_negcyc    <= 1'b0;
            r_ran       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_num_nodes <= i_cfg_wdata;
            end
            if (i_cmd.accept && (t_kind'(i_kind) == KIND_CLR)) begin
                r_count <= '0;
            end else if (i_cmd.accept && (t_kind'(i_kind) == KIND_ADD) && w_add_ok) begin
                r_count <= r_count + ECNT_W'(1);
            end
            if (w_accept_kind_run) begin
                r_negcyc <= 1'b0;
                r_ran    <= 1'b1;
            end else if (w_neg_hit) begin
                r_negcyc <= 1'b1;
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result word; the distance is zero unless a query answers reached.
    // The run answer also counts the edge being updated in this cycle.
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_dist <= '0;
            case (i_cmd.out_sel)
                OUT_ADD: begin
                    r_out_status <= w_add_ok ? ST_OK : ST_REJECTED;
                end
                OUT_RUN_BAD: begin
                    r_out_status <= ST_UNREACH;
                end
                OUT_RUN_DONE: begin
                    r_out_status <= (r_negcyc || w_neg_hit) ? ST_NEGCYC : ST_OK;
                end
                default: begin
                    if (r_negcyc) begin
                        r_out_status <= ST_NEGCYC;
                    end else if (!r_ran || ({1'b0, r_node} >= w_n) || !r_rd_a[DIST_W]) begin
                        r_out_status <= ST_UNREACH;
                    end else begin
                        r_out_status <= ST_OK;
                        r_out_dist   <= r_rd_a[DIST_W-1:0];
                    end
                end
            endcase
        end
    end

    assign o_stat.edge_count = r_count;
    assign o_stat.n_act      = w_n;
    assign o_stat.src_bad    = ({1'b0, r_node} >= w_n);
    assign o_stat.out_free   = !r_out_valid || i_out_ready;
    assign o_out_valid       = r_out_valid;
    assign o_out_status      = r_out_status;
    assign o_out_distance    = r_out_dist;

endmodule

[rtl/core/bellman_ford_shortest_path.sv]
// An add-edge word answers in the cycle after acceptance, a query from the
// S_QRESP state; a clear word gives no result. A run clears all MAX_NODES
// reached bits, seeds the source, then makes n passes of a pass start and
// fetch, read, sum, update per edge; input is held off. Throughput: one edge
// word per cycle while results are taken; a query holds off input until done.
// Reset (synchronous, active low) empties the edge store and result slot.
// ----------------------------------------------------------------------------
// Bellman-Ford shortest-path engine
// Single-source shortest paths over a loadable edge store, with negative
// cycle detection and per-node distance queries.
// ----------------------------------------------------------------------------
module bellman_ford_shortest_path import bfsp_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    bfsp_in_if.sink          i_item,
    bfsp_out_if.source       o_result,
    input  logic             i_cfg_we,
    input  logic [CNT_W-1:0] i_cfg_wdata
);

    // The controller only issues commands; all storage and arithmetic is in
    // the datapath. Edges are relaxed one at a time: fetch the edge, read
    // both endpoint records, form the saturated sum, then compare and write.
    // The final pass writes nothing and only raises the negative-cycle flag.
    t_cmd  w_cmd;
    t_stat w_stat;

    bfsp_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_item.valid),
        .i_kind  (i_item.kind),
        .i_stat  (w_stat),
        .o_ready (i_item.ready),
        .o_cmd   (w_cmd)
    );

    bfsp_dpath u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .i_kind         (i_item.kind),
        .i_edge_from    (i_item.edge_from),
        .i_edge_to      (i_item.edge_to),
        .i_edge_weight  (i_item.edge_weight),
        .i_node         (i_item.node),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_out_ready    (o_result.ready),
        .o_stat         (w_stat),
        .o_out_valid    (o_result.valid),
        .o_out_status   (o_result.status),
        .o_out_distance (o_result.distance)
    );

endmodule

[rtl/core/bfsp_checker.sv]
// ----------------------------------------------------------------------------
// Shortest-path engine port checker
// Watches the top-level ports for handshake and sequencing slips.
// ----------------------------------------------------------------------------
module bfsp_checker import bfsp_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              i_in_ready,
    input logic [1:0]        i_in_kind,
    input logic              i_out_valid,
    input logic              i_out_ready,
    input logic [1:0]        i_out_status,
    input logic [DIST_W-1:0] i_out_distance
);

    logic w_acc;
    assign w_acc = i_in_valid && i_in_ready;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result word dropped before it was taken");

    a_dist_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_out_status != ST_OK) |-> (i_out_distance == '0))
        else $error("non-zero distance on a non-ok result");

    a_clr_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc && (i_in_kind == KIND_CLR) |=> !i_out_valid)
        else $error("clear word produced a result");

    a_run_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc && (i_in_kind == KIND_RUN) |=> !i_in_ready)
        else $error("input accepted right after a run began");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

endmodule

bind bellman_ford_shortest_path bfsp_checker u_bfsp_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_item.valid),
    .i_in_ready     (i_item.ready),
    .i_in_kind      (i_item.kind),
    .i_out_valid    (o_result.valid),
    .i_out_ready    (o_result.ready),
    .i_out_status   (o_result.status),
    .i_out_distance (o_result.distance)
);
